// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; every macro expects signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");

// Implication with a delay given by dly, disabled while in reset
`define ASSERT_AFTER(label, ante, dly, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error("delayed check failed");

`endif

// ===== sv/h2r_pkg.sv =====
// Shared widths, constants and stage structs for the HSV to RGB converter.
// No dependencies.
package h2r_pkg;

   localparam int HueW    = 16;
   localparam int UnitW   = 13;            // Q1.12 input width
   localparam int ChanW   = 8;
   localparam int ChromaW = 25;            // v*s, at most 2^24
   localparam int FracW   = 17;            // 0..65536
   localparam int SumW    = 41;            // channel sum, at most 2^40
   localparam int Latency = 4;

   localparam logic [UnitW-1:0] OneQ12   = 13'd4096;
   localparam logic [FracW-1:0] FullFrac = 17'd65536;

   typedef enum logic [2:0] {
      SEXT_RED_UP   = 3'd0,
      SEXT_GRN_UP   = 3'd1,
      SEXT_GRN_DN   = 3'd2,
      SEXT_BLU_UP   = 3'd3,
      SEXT_BLU_DN   = 3'd4,
      SEXT_RED_DN   = 3'd5
   } sextant_type;

   typedef struct packed {
      sextant_type        sextant;
      logic [FracW-1:0]   frac;     // already mirrored in odd sextants
      logic [ChromaW-1:0] chroma;   // scale 2^-24
      logic [UnitW-1:0]   value;    // clamped, Q1.12
   } h2r_front_type;

   typedef struct packed {
      sextant_type        sextant;
      logic [SumW-1:0]    second;   // x, scale 2^-40
      logic [ChromaW-1:0] chroma;   // scale 2^-24
      logic [ChromaW-1:0] offset;   // m, scale 2^-24
   } h2r_chroma_type;

   typedef struct packed {
      logic [SumW-1:0] red;
      logic [SumW-1:0] green;
      logic [SumW-1:0] blue;
   } h2r_mix_type;

endpackage

// ===== sv/h2r_front.sv =====
// Stage 1: clamps saturation and value, finds the hue sextant and fraction,
// multiplies chroma. Depends on h2r_pkg.
module h2r_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [h2r_pkg::HueW-1:0]  hue,
   input  logic [h2r_pkg::UnitW-1:0] saturation,
   input  logic [h2r_pkg::UnitW-1:0] brightness,
   output logic                    out_valid_ff,
   output h2r_pkg::h2r_front_type  out_data_ff
);
   import h2r_pkg::*;

   logic [UnitW-1:0]   sat_clamp;
   logic [UnitW-1:0]   val_clamp;
   logic [HueW+2:0]    hue6;
   logic [2*UnitW-1:0] product;
   h2r_front_type      data_in;

   always_comb begin
      sat_clamp = (saturation > OneQ12) ? OneQ12 : saturation;
      val_clamp = (brightness > OneQ12) ? OneQ12 : brightness;
      hue6      = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
      product   = sat_clamp * val_clamp;
      data_in.sextant = sextant_type'(hue6[HueW+2:HueW]);
      data_in.frac    = hue6[HueW] ? (FullFrac - {1'b0, hue6[HueW-1:0]})
                                   : {1'b0, hue6[HueW-1:0]};
      data_in.chroma  = product[ChromaW-1:0];
      data_in.value   = val_clamp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
      out_data_ff <= data_in;
   end

endmodule

// ===== sv/h2r_chroma.sv =====
// Stage 2: second-largest component x = c*f and the offset m = v - c.
// Depends on h2r_pkg.
module h2r_chroma (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  h2r_pkg::h2r_front_type  in_data,
   output logic                    out_valid_ff,
   output h2r_pkg::h2r_chroma_type out_data_ff
);
   import h2r_pkg::*;

   logic [ChromaW+FracW-1:0] product;
   h2r_chroma_type           data_in;

   always_comb begin
      product         = in_data.chroma * in_data.frac;
      data_in.sextant = in_data.sextant;
      data_in.second  = product[SumW-1:0];
      data_in.chroma  = in_data.chroma;
      data_in.offset  = {in_data.value, 12'd0} - in_data.chroma;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
      out_data_ff <= data_in;
   end

endmodule

// ===== sv/h2r_mix.sv =====
// Stage 3: routes c, x and 0 to the channels by sextant and adds m.
// Depends on h2r_pkg.
module h2r_mix (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  h2r_pkg::h2r_chroma_type in_data,
   output logic                    out_valid_ff,
   output h2r_pkg::h2r_mix_type    out_data_ff
);
   import h2r_pkg::*;

   logic [SumW-1:0] big;
   logic [SumW-1:0] mid;
   logic [SumW-1:0] base;
   logic [SumW-1:0] red_part;
   logic [SumW-1:0] green_part;
   logic [SumW-1:0] blue_part;
   h2r_mix_type     data_in;

   always_comb begin
      big  = {in_data.chroma, 16'd0};
      mid  = in_data.second;
      base = {in_data.offset, 16'd0};
      case (in_data.sextant)
         SEXT_RED_UP: begin
            red_part = big;  green_part = mid;  blue_part = '0;
         end
         SEXT_GRN_UP: begin
            red_part = mid;  green_part = big;  blue_part = '0;
         end
         SEXT_GRN_DN: begin
            red_part = '0;   green_part = big;  blue_part = mid;
         end
         SEXT_BLU_UP: begin
            red_part = '0;   green_part = mid;  blue_part = big;
         end
         SEXT_BLU_DN: begin
            red_part = mid;  green_part = '0;   blue_part = big;
         end
         default: begin
            red_part = big;  green_part = '0;   blue_part = mid;
         end
      endcase
      data_in.red   = red_part + base;
      data_in.green = green_part + base;
      data_in.blue  = blue_part + base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
      out_data_ff <= data_in;
   end

endmodule

// ===== sv/h2r_round.sv =====
// Stage 4: scales each channel sum by 255 and rounds half up to 8 bits.
// Depends on h2r_pkg.
module h2r_round (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  h2r_pkg::h2r_mix_type         in_data,
   output logic                         out_valid_ff,
   output logic [h2r_pkg::ChanW-1:0]    red_ff,
   output logic [h2r_pkg::ChanW-1:0]    green_ff,
   output logic [h2r_pkg::ChanW-1:0]    blue_ff
);
   import h2r_pkg::*;

   localparam int ScaleW = SumW + ChanW;

   logic [ChanW-1:0] red_in;
   logic [ChanW-1:0] green_in;
   logic [ChanW-1:0] blue_in;

   // (v*255 + 2^39) >> 40, with v*255 done as v*256 - v
   function automatic logic [ChanW-1:0] to_byte(input logic [SumW-1:0] sum);
      logic [ScaleW-1:0] scaled;
      scaled = {sum, {ChanW{1'b0}}} - {{ChanW{1'b0}}, sum}
             + {{(ScaleW-SumW+1){1'b0}}, 1'b1, {(SumW-2){1'b0}}};
      return scaled[SumW+ChanW-2:SumW-1];
   endfunction

   always_comb begin
      red_in   = to_byte(in_data.red);
      green_in = to_byte(in_data.green);
      blue_in  = to_byte(in_data.blue);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

endmodule

// ===== sv/hsv_to_rgb_converter_unit.sv =====
// Top level of the HSV to RGB converter: four-stage pipeline.
// Depends on h2r_pkg, h2r_front, h2r_chroma, h2r_mix, h2r_round.
//
//   channel   handshake           payload
//   request   start / busy        req_hue, req_saturation, req_brightness
//   response  rsp_valid (strobe)  rsp_red, rsp_green, rsp_blue
//
// One transaction per clock while busy is low; each one yields one rsp_valid strobe.
// Depth: two chained multiplies (v*s, then c*f), the add of m, and the x255 round.
// busy is high only while reset is asserted; reset clears the stage valid bits.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module hsv_to_rgb_converter_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [h2r_pkg::HueW-1:0]    req_hue,
   input  logic [h2r_pkg::UnitW-1:0]   req_saturation,
   input  logic [h2r_pkg::UnitW-1:0]   req_brightness,
   output logic                        rsp_valid,
   output logic [h2r_pkg::ChanW-1:0]   rsp_red,
   output logic [h2r_pkg::ChanW-1:0]   rsp_green,
   output logic [h2r_pkg::ChanW-1:0]   rsp_blue
);
   import h2r_pkg::*;

   logic           accept;
   logic           front_valid;
   h2r_front_type  front_data;
   logic           chroma_valid;
   h2r_chroma_type chroma_data;
   logic           mix_valid;
   h2r_mix_type    mix_data;

   assign busy   = reset;
   assign accept = start & ~busy;

   h2r_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .hue          (req_hue),
      .saturation   (req_saturation),
      .brightness   (req_brightness),
      .out_valid_ff (front_valid),
      .out_data_ff  (front_data)
   );

   h2r_chroma u_chroma (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (front_valid),
      .in_data      (front_data),
      .out_valid_ff (chroma_valid),
      .out_data_ff  (chroma_data)
   );

   h2r_mix u_mix (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chroma_valid),
      .in_data      (chroma_data),
      .out_valid_ff (mix_valid),
      .out_data_ff  (mix_data)
   );

   h2r_round u_round (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (mix_valid),
      .in_data      (mix_data),
      .out_valid_ff (rsp_valid),
      .red_ff       (rsp_red),
      .green_ff     (rsp_green),
      .blue_ff      (rsp_blue)
   );

endmodule

// ===== sv/h2r_checker.sv =====
// Port-level checks for the HSV to RGB converter, bound to the top level.
// Depends on h2r_pkg and assert_macros.svh.
`include "assert_macros.svh"

module h2r_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [h2r_pkg::UnitW-1:0]   req_saturation,
   input logic [h2r_pkg::UnitW-1:0]   req_brightness,
   input logic                        rsp_valid,
   input logic [h2r_pkg::ChanW-1:0]   rsp_red,
   input logic [h2r_pkg::ChanW-1:0]   rsp_green,
   input logic [h2r_pkg::ChanW-1:0]   rsp_blue
);
   import h2r_pkg::*;

   logic accept;
   logic rsp_black;
   logic rsp_gray;
   assign accept    = start & ~busy;
   assign rsp_black = (rsp_red == '0) && (rsp_green == '0) && (rsp_blue == '0);
   assign rsp_gray  = (rsp_red == rsp_green) && (rsp_green == rsp_blue);

   // every accepted transaction produces an rsp_valid strobe
   `ASSERT_AFTER(a_resp_follows, accept, Latency, rsp_valid)
   `ASSERT_IMPLIES(a_no_spurious, rsp_valid, $past(accept, Latency))
   // zero value gives black
   `ASSERT_AFTER(a_black, accept && (req_brightness == '0), Latency, rsp_black)
   // zero saturation gives gray
   `ASSERT_AFTER(a_gray, accept && (req_saturation == '0), Latency, rsp_gray)

endmodule

bind hsv_to_rgb_converter_unit h2r_checker u_h2r_checker (.*);
